// ===== src/gqi_pkg.sv =====
// types, constants and the product term table of the gyro quaternion integrator
package gqi_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned ACC_W     = 50;
    localparam int unsigned MUL_W     = ACC_W + DATA_W;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned MUL_STEPS = DATA_W / DIGIT_W;

    localparam logic [DATA_W-1:0] ONE_Q30       = 32'h4000_0000;
    localparam logic [DATA_W-1:0] SYM_MAX       = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_MAX       = 32'h8000_0000;
    localparam logic [DATA_W-1:0] HALF_STEP_RST = 32'd2147484;

    localparam logic [1:0] REG_BIAS_X    = 2'd0;
    localparam logic [1:0] REG_BIAS_Y    = 2'd1;
    localparam logic [1:0] REG_BIAS_Z    = 2'd2;
    localparam logic [1:0] REG_HALF_STEP = 2'd3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PLOAD,
        ST_PMUL,
        ST_PACC,
        ST_SLOAD,
        ST_SMUL,
        ST_NSTEP,
        ST_QMUL,
        ST_QACC,
        ST_ROOT,
        ST_RCHK,
        ST_DLOAD,
        ST_DIV,
        ST_DRES,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0] rsel;
        logic [1:0] qsel;
        logic       neg;
    } term_t;

    // rate axis, attitude component and sign of each product term of omega times q
    function automatic term_t term_sel(input logic [1:0] comp, input logic [1:0] term);
        term_t t;
        t = '{rsel: AXIS_X, qsel: 2'd0, neg: 1'b0};
        unique case ({comp, term})
            4'b00_00: t = '{rsel: AXIS_X, qsel: 2'd1, neg: 1'b1};
            4'b00_01: t = '{rsel: AXIS_Y, qsel: 2'd2, neg: 1'b1};
            4'b00_10: t = '{rsel: AXIS_Z, qsel: 2'd3, neg: 1'b1};
            4'b01_00: t = '{rsel: AXIS_X, qsel: 2'd0, neg: 1'b0};
            4'b01_01: t = '{rsel: AXIS_Z, qsel: 2'd2, neg: 1'b0};
            4'b01_10: t = '{rsel: AXIS_Y, qsel: 2'd3, neg: 1'b1};
            4'b10_00: t = '{rsel: AXIS_Y, qsel: 2'd0, neg: 1'b0};
            4'b10_01: t = '{rsel: AXIS_Z, qsel: 2'd1, neg: 1'b1};
            4'b10_10: t = '{rsel: AXIS_X, qsel: 2'd3, neg: 1'b0};
            4'b11_00: t = '{rsel: AXIS_Z, qsel: 2'd0, neg: 1'b0};
            4'b11_01: t = '{rsel: AXIS_Y, qsel: 2'd1, neg: 1'b0};
            4'b11_10: t = '{rsel: AXIS_X, qsel: 2'd2, neg: 1'b1};
            default:  t = '{rsel: AXIS_X, qsel: 2'd0, neg: 1'b0};
        endcase
        return t;
    endfunction

endpackage

// ===== src/gyro_quaternion_integrator.sv =====
// gyro quaternion integrator: bias removal, euler step, renormalisation
//
// s_ channel: one gyro sample per transfer, three q16.16 rates in rad/s.
// m_ channel: one result per sample, the renormalised attitude quaternion
// in q2.30, which also becomes the stored attitude for the next sample.
// cfg port: biases (index 0..2, q16.16) and half sample period (index 3, q0.32);
// the user writes them only while the block is idle, which it does not enforce.
// The time from a sample's transfer to its result is set by the shared
// 4-bit-per-cycle multiplier (20 products, each with a load and an accumulate
// step), the 32-step bit-serial square root and four 32-step bit-serial
// divisions; a division whose quotient is sure to saturate is skipped.
// A zero norm skips the divisions and repeats the old attitude.
// One sample is worked on at a time; s_tready is high only while idle, so a
// new sample is taken only once the last one has passed its final step.
// The result sits in an output register, so the next sample is taken while
// it waits; a stalled receiver holds the block in its last step until the
// output register is free.
// Reset clears the biases, loads the default half period and sets the
// attitude to the identity quaternion (1, 0, 0, 0).
module gyro_quaternion_integrator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // rate_x, rate_y, rate_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // quat_w, quat_x, quat_y, quat_z
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    localparam int unsigned DW = gqi_pkg::DATA_W;
    localparam int unsigned AW = gqi_pkg::ACC_W;
    localparam int unsigned MW = gqi_pkg::MUL_W;
    localparam int unsigned GW = gqi_pkg::DIGIT_W;

    gqi_pkg::state_t state_reg, state_next;

    logic [4:0]           cnt_reg;
    logic [1:0]           comp_reg;
    logic [1:0]           term_reg;
    logic signed [DW-1:0] bias_reg [3];
    logic [DW-1:0]        half_step_reg;
    logic signed [DW-1:0] rate_reg [3];
    logic signed [DW-1:0] q_reg [4];
    logic signed [DW-1:0] n_reg [4];
    logic signed [DW-1:0] res_reg [4];
    logic [AW-1:0]        mcand_reg;
    logic [MW-1:0]        mul_reg;
    logic                 psign_reg;
    logic                 tneg_reg;
    logic signed [AW-1:0] acc_reg;
    logic [63:0]          sumsq_reg;
    logic [DW-1:0]        root_reg;
    logic [33:0]          rem_reg;
    logic [DW-1:0]        drem_reg;
    logic [DW-1:0]        dlo_reg;
    logic [DW-1:0]        quot_reg;
    logic                 m_tvalid_reg;
    logic [127:0]         m_tdata_reg;

    gqi_pkg::term_t       term;
    logic signed [DW-1:0] r_sel;
    logic signed [DW-1:0] q_sel;
    logic                 mul_last;
    logic [AW+GW-1:0]     mul_sum;
    logic [MW-1:0]        mul_next;
    logic [63:0]          prod_rnd;
    logic [47:0]          term_mag;
    logic signed [AW-1:0] term_val;
    logic [AW-1:0]        acc_abs;
    logic signed [51:0]   inc_val;
    logic signed [51:0]   n_sum;
    logic signed [DW-1:0] n_sat;
    logic [63:0]          sumsq_next;
    logic [35:0]          rt_shift;
    logic [35:0]          rt_trial;
    logic [DW-1:0]        dm;
    logic                 div_ovf;
    logic [DW:0]          dv_shift;
    logic                 out_free;

    function automatic logic [DW-1:0] abs32(input logic signed [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic signed [DW-1:0] sub_sat(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] d;
        d = {a[DW-1], a} - {b[DW-1], b};
        if (d[DW] != d[DW-1]) begin
            return d[DW] ? gqi_pkg::NEG_MAX : gqi_pkg::SYM_MAX;
        end
        return d[DW-1:0];
    endfunction

    // quotient magnitude to signed q2.30, saturating at 2^31
    function automatic logic signed [DW-1:0] quot_sat(input logic neg, input logic big,
                                                      input logic [DW-1:0] mag);
        if (big || mag[DW-1]) begin
            return neg ? gqi_pkg::NEG_MAX : gqi_pkg::SYM_MAX;
        end
        return neg ? (~mag + 1'b1) : mag;
    endfunction

    always_comb begin
        term = gqi_pkg::term_sel(comp_reg, term_reg);
        unique case (term.rsel)
            gqi_pkg::AXIS_X: r_sel = rate_reg[0];
            gqi_pkg::AXIS_Y: r_sel = rate_reg[1];
            default:         r_sel = rate_reg[2];
        endcase
        q_sel = q_reg[term.qsel];

        // one 4-bit digit of the multiplier per cycle
        mul_last = (cnt_reg == 5'(gqi_pkg::MUL_STEPS - 1));
        mul_sum  = {{GW{1'b0}}, mul_reg[MW-1:DW]} + mcand_reg * mul_reg[GW-1:0];
        mul_next = {mul_sum, mul_reg[DW-1:GW]};

        // floor of the signed product over 2^16
        prod_rnd = mul_reg[63:0] + 64'd65535;
        term_mag = psign_reg ? prod_rnd[63:16] : mul_reg[63:16];
        term_val = (psign_reg ^ tneg_reg) ? -$signed({2'b00, term_mag})
                                          :  $signed({2'b00, term_mag});
        acc_abs  = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);

        inc_val = psign_reg ? -$signed({2'b00, mul_reg[MW-1:DW]})
                            :  $signed({2'b00, mul_reg[MW-1:DW]});
        n_sum   = {{20{q_reg[comp_reg][DW-1]}}, q_reg[comp_reg]} + inc_val;
        if (n_sum > $signed({20'd0, gqi_pkg::SYM_MAX})) begin
            n_sat = gqi_pkg::SYM_MAX;
        end else if (n_sum < -$signed({20'd0, gqi_pkg::SYM_MAX})) begin
            n_sat = -gqi_pkg::SYM_MAX;
        end else begin
            n_sat = n_sum[DW-1:0];
        end

        sumsq_next = sumsq_reg + mul_reg[63:0];

        rt_shift = {rem_reg, sumsq_reg[63:62]};
        rt_trial = {2'b00, root_reg, 2'b01};

        dm       = abs32(n_reg[comp_reg]);
        div_ovf  = ({2'b00, dm[DW-1:2]}) >= root_reg;
        dv_shift = {drem_reg, dlo_reg[DW-1]};

        out_free = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gqi_pkg::ST_IDLE:  if (s_tvalid) state_next = gqi_pkg::ST_PLOAD;
            gqi_pkg::ST_PLOAD: state_next = gqi_pkg::ST_PMUL;
            gqi_pkg::ST_PMUL:  if (mul_last) state_next = gqi_pkg::ST_PACC;
            gqi_pkg::ST_PACC:  state_next = (term_reg == 2'd2) ? gqi_pkg::ST_SLOAD
                                                              : gqi_pkg::ST_PLOAD;
            gqi_pkg::ST_SLOAD: state_next = gqi_pkg::ST_SMUL;
            gqi_pkg::ST_SMUL:  if (mul_last) state_next = gqi_pkg::ST_NSTEP;
            gqi_pkg::ST_NSTEP: state_next = gqi_pkg::ST_QMUL;
            gqi_pkg::ST_QMUL:  if (mul_last) state_next = gqi_pkg::ST_QACC;
            gqi_pkg::ST_QACC:  state_next = (comp_reg == 2'd3) ? gqi_pkg::ST_ROOT
                                                              : gqi_pkg::ST_PLOAD;
            gqi_pkg::ST_ROOT:  if (cnt_reg == 5'd31) state_next = gqi_pkg::ST_RCHK;
            gqi_pkg::ST_RCHK:  state_next = (root_reg == '0) ? gqi_pkg::ST_OUT
                                                            : gqi_pkg::ST_DLOAD;
            gqi_pkg::ST_DLOAD: begin
                if (!div_ovf) begin
                    state_next = gqi_pkg::ST_DIV;
                end else if (comp_reg == 2'd3) begin
                    state_next = gqi_pkg::ST_OUT;
                end
            end
            gqi_pkg::ST_DIV:   if (cnt_reg == 5'd31) state_next = gqi_pkg::ST_DRES;
            gqi_pkg::ST_DRES:  state_next = (comp_reg == 2'd3) ? gqi_pkg::ST_OUT
                                                              : gqi_pkg::ST_DLOAD;
            gqi_pkg::ST_OUT:   if (out_free) state_next = gqi_pkg::ST_IDLE;
            default:           state_next = gqi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gqi_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration and attitude
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg[0]   <= '0;
            bias_reg[1]   <= '0;
            bias_reg[2]   <= '0;
            half_step_reg <= gqi_pkg::HALF_STEP_RST;
            q_reg[0]      <= gqi_pkg::ONE_Q30;
            q_reg[1]      <= '0;
            q_reg[2]      <= '0;
            q_reg[3]      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    gqi_pkg::REG_BIAS_X:    bias_reg[0]   <= cfg_wdata;
                    gqi_pkg::REG_BIAS_Y:    bias_reg[1]   <= cfg_wdata;
                    gqi_pkg::REG_BIAS_Z:    bias_reg[2]   <= cfg_wdata;
                    gqi_pkg::REG_HALF_STEP: half_step_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (state_reg == gqi_pkg::ST_OUT && out_free) begin
                for (int i = 0; i < 4; i++) begin
                    q_reg[i] <= res_reg[i];
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            gqi_pkg::ST_PMUL, gqi_pkg::ST_SMUL, gqi_pkg::ST_QMUL,
            gqi_pkg::ST_ROOT, gqi_pkg::ST_DIV: cnt_reg <= cnt_reg + 5'd1;
            default:                            cnt_reg <= '0;
        endcase

        unique case (state_reg)
            gqi_pkg::ST_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    rate_reg[i] <= sub_sat(s_tdata[i*DW +: DW], bias_reg[i]);
                end
                comp_reg  <= '0;
                term_reg  <= '0;
                acc_reg   <= '0;
                sumsq_reg <= '0;
            end
            gqi_pkg::ST_PLOAD: begin
                mcand_reg <= {{(AW-DW){1'b0}}, abs32(r_sel)};
                mul_reg   <= {{AW{1'b0}}, abs32(q_sel)};
                psign_reg <= r_sel[DW-1] ^ q_sel[DW-1];
                tneg_reg  <= term.neg;
            end
            gqi_pkg::ST_PMUL, gqi_pkg::ST_SMUL, gqi_pkg::ST_QMUL: begin
                mul_reg <= mul_next;
            end
            gqi_pkg::ST_PACC: begin
                acc_reg  <= acc_reg + term_val;
                term_reg <= term_reg + 2'd1;
            end
            gqi_pkg::ST_SLOAD: begin
                mcand_reg <= acc_abs;
                mul_reg   <= {{AW{1'b0}}, half_step_reg};
                psign_reg <= acc_reg[AW-1];
            end
            gqi_pkg::ST_NSTEP: begin
                n_reg[comp_reg] <= n_sat;
                mcand_reg       <= {{(AW-DW){1'b0}}, abs32(n_sat)};
                mul_reg         <= {{AW{1'b0}}, abs32(n_sat)};
            end
            gqi_pkg::ST_QACC: begin
                sumsq_reg <= sumsq_next;
                comp_reg  <= comp_reg + 2'd1;
                term_reg  <= '0;
                acc_reg   <= '0;
                root_reg  <= '0;
                rem_reg   <= '0;
            end
            gqi_pkg::ST_ROOT: begin
                // one result bit per cycle, two radicand bits shifted in
                sumsq_reg <= {sumsq_reg[61:0], 2'b00};
                if (rt_shift >= rt_trial) begin
                    rem_reg  <= 34'(rt_shift - rt_trial);
                    root_reg <= {root_reg[DW-2:0], 1'b1};
                end else begin
                    rem_reg  <= rt_shift[33:0];
                    root_reg <= {root_reg[DW-2:0], 1'b0};
                end
            end
            gqi_pkg::ST_RCHK: begin
                comp_reg <= '0;
                if (root_reg == '0) begin
                    for (int i = 0; i < 4; i++) begin
                        res_reg[i] <= q_reg[i];
                    end
                end
            end
            gqi_pkg::ST_DLOAD: begin
                drem_reg <= {2'b00, dm[DW-1:2]};
                dlo_reg  <= {dm[1:0], {(DW-2){1'b0}}};
                quot_reg <= '0;
                if (div_ovf) begin
                    res_reg[comp_reg] <= quot_sat(n_reg[comp_reg][DW-1], 1'b1, '0);
                    comp_reg          <= comp_reg + 2'd1;
                end
            end
            gqi_pkg::ST_DIV: begin
                dlo_reg <= {dlo_reg[DW-2:0], 1'b0};
                if (dv_shift >= {1'b0, root_reg}) begin
                    drem_reg <= DW'(dv_shift - {1'b0, root_reg});
                    quot_reg <= {quot_reg[DW-2:0], 1'b1};
                end else begin
                    drem_reg <= dv_shift[DW-1:0];
                    quot_reg <= {quot_reg[DW-2:0], 1'b0};
                end
            end
            gqi_pkg::ST_DRES: begin
                res_reg[comp_reg] <= quot_sat(n_reg[comp_reg][DW-1], 1'b0, quot_reg);
                comp_reg          <= comp_reg + 2'd1;
            end
            gqi_pkg::ST_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == gqi_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/sv/tb_gyro_quaternion_integrator.sv =====
// testbench for the gyro quaternion integrator: self-checking, random and directed samples
`timescale 1ns / 1ps

module tb_gyro_quaternion_integrator;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 800;

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
        logic signed [31:0] w;
    } quat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;

    gyro_quaternion_integrator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // predictor state
    logic signed [31:0] bias_q[3];
    logic [31:0]        half_period;
    logic signed [31:0] att_q[4];
    quat_t              quat_queue[$];

    int  error_count = 0;
    int  samples_sent = 0;
    int  quats_checked = 0;
    int  idle_cycles = 0;
    int  rx_idle_left = 0;
    bit  idling_on = 1'b1;
    bit  hold_off = 1'b0;
    int  zero_norm_hits = 0;

    function automatic longint floor_q16(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint step_scale(longint s, logic [31:0] h);
        logic [63:0] m;
        logic [63:0] r;
        m = s < 0 ? -s : s;
        r = m[63:32] * {32'd0, h} + ((m[31:0] * {32'd0, h}) >> 32);
        return s < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    task automatic propagate_attitude(input logic [31:0] rx_in, ry_in, rz_in);
        longint r[3], q[4], s[4], n[4], v;
        logic [63:0] sumsq, norm, m, d;
        quat_t e;
        r[0] = sat(longint'($signed(rx_in)) - bias_q[0], -64'sd2147483648, 64'sd2147483647);
        r[1] = sat(longint'($signed(ry_in)) - bias_q[1], -64'sd2147483648, 64'sd2147483647);
        r[2] = sat(longint'($signed(rz_in)) - bias_q[2], -64'sd2147483648, 64'sd2147483647);
        for (int i = 0; i < 4; i++) q[i] = att_q[i];
        s[0] = -floor_q16(r[0], q[1]) - floor_q16(r[1], q[2]) - floor_q16(r[2], q[3]);
        s[1] =  floor_q16(r[0], q[0]) + floor_q16(r[2], q[2]) - floor_q16(r[1], q[3]);
        s[2] =  floor_q16(r[1], q[0]) - floor_q16(r[2], q[1]) + floor_q16(r[0], q[3]);
        s[3] =  floor_q16(r[2], q[0]) + floor_q16(r[1], q[1]) - floor_q16(r[0], q[2]);
        sumsq = 0;
        for (int i = 0; i < 4; i++) begin
            n[i] = sat(q[i] + step_scale(s[i], half_period), -64'sd2147483647, 64'sd2147483647);
            sumsq = sumsq + 64'(n[i] * n[i]);
        end
        norm = root_floor(sumsq);
        if (norm != 0) begin
            for (int i = 0; i < 4; i++) begin
                m = n[i] < 0 ? -n[i] : n[i];
                d = (m << 30) / norm;
                if (d > 64'd2147483648) d = 64'd2147483648;
                v = n[i] < 0 ? -longint'(d) : longint'(d);
                att_q[i] = 32'(sat(v, -64'sd2147483648, 64'sd2147483647));
            end
        end else begin
            zero_norm_hits++;
        end
        e.w = att_q[0]; e.x = att_q[1]; e.y = att_q[2]; e.z = att_q[3];
        quat_queue.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
        $display("mismatch %s: got %08h expected %08h (result %0d)", what, got, exp_v,
                 quats_checked);
        error_count++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            gqi_pkg::REG_BIAS_X:    bias_q[0] = val;
            gqi_pkg::REG_BIAS_Y:    bias_q[1] = val;
            gqi_pkg::REG_BIAS_Z:    bias_q[2] = val;
            gqi_pkg::REG_HALF_STEP: half_period = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (quat_queue.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // send one sample; called at a falling edge, drives from the next one, or later while idling is on
    task automatic send_sample(input logic [31:0] rx, ry, rz);
        @(negedge aclk);
        if (idling_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {rz, ry, rx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        propagate_attitude(rx, ry, rz);
        samples_sent++;
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_rate();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    // receiver side, idling in random bursts
    always @(negedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else if (rx_idle_left > 0) begin
            m_tready     <= 1'b0;
            rx_idle_left <= rx_idle_left - 1;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            m_tready     <= 1'b0;
            rx_idle_left <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        quat_t got, exp_q;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (quat_queue.size() == 0) begin
                report_mismatch("unexpected result", got.w, '0);
            end else begin
                exp_q = quat_queue.pop_front();
                if (got.w !== exp_q.w) report_mismatch("quat_w", got.w, exp_q.w);
                if (got.x !== exp_q.x) report_mismatch("quat_x", got.x, exp_q.x);
                if (got.y !== exp_q.y) report_mismatch("quat_y", got.y, exp_q.y);
                if (got.z !== exp_q.z) report_mismatch("quat_z", got.z, exp_q.z);
            end
            quats_checked++;
        end
    end

    // stall watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || cfg_wr_en)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_sample(0, 0, 0);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_sample(32'h0001_0000, 0, 0);
        send_sample(0, 32'hFFFF_0000, 0);
        send_sample(0, 0, 32'h0003_0000);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555);
        wait_drained();
        // rate saturation through the bias subtraction
        write_reg(gqi_pkg::REG_BIAS_X, 32'h8000_0000);
        write_reg(gqi_pkg::REG_BIAS_Y, 32'h7FFF_FFFF);
        write_reg(gqi_pkg::REG_BIAS_Z, 32'h0001_0000);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'hAAAA_AAAA);
        wait_drained();
        // largest step: components saturate; zero step keeps the attitude
        write_reg(gqi_pkg::REG_HALF_STEP, 32'hFFFF_FFFF);
        send_sample(32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h0040_0000, 32'hFFC0_0000, 32'h0020_0000);
        wait_drained();
        write_reg(gqi_pkg::REG_HALF_STEP, 32'd0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        wait_drained();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(gqi_pkg::REG_BIAS_X, phase == 0 ? 32'd0 : rand_rate());
            write_reg(gqi_pkg::REG_BIAS_Y, phase == 0 ? 32'd0 : rand_rate());
            write_reg(gqi_pkg::REG_BIAS_Z, phase == 0 ? 32'd0 : rand_rate());
            case (phase % 4)
                0: write_reg(gqi_pkg::REG_HALF_STEP, gqi_pkg::HALF_STEP_RST);
                1: write_reg(gqi_pkg::REG_HALF_STEP, $urandom());
                2: write_reg(gqi_pkg::REG_HALF_STEP, $urandom_range(0, 1 << 24));
                default: write_reg(gqi_pkg::REG_HALF_STEP,
                                   $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1);
            endcase
            for (int k = 0; k < 120; k++) send_sample(rand_rate(), rand_rate(), rand_rate());
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 4; k++) send_sample(rand_rate(), rand_rate(), rand_rate());
        join
        wait_drained();
    endtask

    task automatic test_no_idling();
        idling_on = 1'b0;
        write_reg(gqi_pkg::REG_HALF_STEP, $urandom_range(0, 1 << 26));
        for (int k = 0; k < 180; k++) send_sample(rand_rate(), rand_rate(), rand_rate());
    endtask

    initial begin
        int waited;
        bias_q = '{0, 0, 0};
        half_period = gqi_pkg::HALF_STEP_RST;
        att_q = '{32'sh4000_0000, 0, 0, 0};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_settings();
        test_backpressure();
        test_no_idling();
        waited = 0;
        while (quat_queue.size() != 0 && waited < 100000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (quat_queue.size() != 0) report_mismatch("missing results", quat_queue.size(), '0);
        $display("covered %0d gyro samples, %0d quaternions checked, %0d zero-norm steps",
                 samples_sent, quats_checked, zero_norm_hits);
        $display("bias and half-period settings swept incl. extremes, with a long receiver stall");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== gyro_quaternion_integrator.f =====
src/gqi_pkg.sv
src/gyro_quaternion_integrator.sv
tb/sv/tb_gyro_quaternion_integrator.sv
